// ===== hdl/hsp_pkg.sv =====
`default_nettype none
package hsp_pkg;

  // Fixed-point format of the results
  localparam int FRAC_BITS = 16;
  localparam int OUT_W     = FRAC_BITS + 1;
  localparam int CH_W      = 8;
  localparam int WGT_W     = 17;
  localparam int SQC_W     = 2 * CH_W;
  localparam int PROD_W    = WGT_W + SQC_W;
  localparam int SUM_W     = PROD_W + 2;

  // Divider datapath widths
  localparam int DIV_W     = 28;
  localparam int DEN_W     = 11;

  // Square root datapath widths
  localparam int SQ_W      = 56;
  localparam int SM_W      = 36;
  localparam int SQ_SHIFT  = 18;

  localparam logic [OUT_W-1:0] ONE    = OUT_W'(1) << FRAC_BITS;
  localparam int               CH_SQ  = 65025;
  localparam logic [SUM_W-1:0] CAP    = SUM_W'(64'd4261478400);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2
  } reg_idx_t;

  // One pixel in flight through the iteration stages
  typedef struct packed {
    logic [CH_W-1:0]         alpha;
    logic                    big;
    logic signed [SQ_W-1:0]  sq_r;
    logic signed [SM_W-1:0]  sq_m;
    logic [OUT_W-1:0]        sq_p;
    logic [DIV_W-1:0]        h_rem;
    logic [DEN_W-1:0]        h_den;
    logic [OUT_W-1:0]        h_q;
    logic [DIV_W-1:0]        s_rem;
    logic [DEN_W-1:0]        s_den;
    logic [OUT_W-1:0]        s_q;
  } work_t;

endpackage
`default_nettype wire

// ===== hdl/hsp_pix_if.sv =====
`default_nettype none
interface hsp_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface
`default_nettype wire

// ===== hdl/hsp_res_if.sv =====
`default_nettype none
interface hsp_res_if;
  logic        valid;
  logic        ready;
  logic [16:0] hue_out;
  logic [16:0] saturation_out;
  logic [16:0] brightness_out;
  logic [7:0]  alpha_out;

  modport source (output valid, hue_out, saturation_out, brightness_out, alpha_out,
                  input ready);
  modport sink   (input valid, hue_out, saturation_out, brightness_out, alpha_out,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/hsp_cfg.sv =====
`default_nettype none
module hsp_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [3:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic [hsp_pkg::WGT_W-1:0]       red_w,
  output logic [hsp_pkg::WGT_W-1:0]       green_w,
  output logic [hsp_pkg::WGT_W-1:0]       blue_w
);
  import hsp_pkg::*;

  logic [WGT_W-1:0] red_w_r, green_w_r, blue_w_r;
  logic             wr_en;
  reg_idx_t         idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[3:2]);

  // Write a weight on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_w_r   <= WGT_W'(19595);
      green_w_r <= WGT_W'(38470);
      blue_w_r  <= WGT_W'(7471);
    end else if (wr_en) begin
      unique case (idx)
        REG_RED:   red_w_r   <= pwdata[WGT_W-1:0];
        REG_GREEN: green_w_r <= pwdata[WGT_W-1:0];
        REG_BLUE:  blue_w_r  <= pwdata[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_RED:   prdata = 32'(red_w_r);
      REG_GREEN: prdata = 32'(green_w_r);
      REG_BLUE:  prdata = 32'(blue_w_r);
      default:   prdata = 32'd0;
    endcase
  end

  assign red_w   = red_w_r;
  assign green_w = green_w_r;
  assign blue_w  = blue_w_r;
endmodule
`default_nettype wire

// ===== hdl/hsp_front.sv =====
`default_nettype none
module hsp_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_vld,
  input  wire logic [7:0]              red,
  input  wire logic [7:0]              green,
  input  wire logic [7:0]              blue,
  input  wire logic [7:0]              alpha,
  input  wire logic [hsp_pkg::WGT_W-1:0] red_w,
  input  wire logic [hsp_pkg::WGT_W-1:0] green_w,
  input  wire logic [hsp_pkg::WGT_W-1:0] blue_w,
  output logic                         out_vld,
  output hsp_pkg::work_t               out_work
);
  import hsp_pkg::*;

  // Stage A: channel order, hue numerator, squares
  logic [CH_W-1:0]  mx, mn, d;
  logic [DEN_W-1:0] d11, num6;
  logic             a_vld_r;
  logic [CH_W-1:0]  a_alpha_r;
  logic [SQC_W-1:0] a_sr_r, a_sg_r, a_sb_r;
  logic [DIV_W-1:0] a_hn_r, a_hn_nxt, a_sn_r, a_sn_nxt;
  logic [DEN_W-1:0] a_hd_r, a_hd_nxt, a_sd_r, a_sd_nxt;

  always_comb begin
    mx  = (red > green) ? red : green;
    mx  = (mx > blue) ? mx : blue;
    mn  = (red < green) ? red : green;
    mn  = (mn < blue) ? mn : blue;
    d   = mx - mn;
    d11 = DEN_W'(d);
    if (red == mx) begin
      num6 = (green == mn) ? DEN_W'(6) * d11 - (DEN_W'(blue) - DEN_W'(green))
                           : DEN_W'(green) - DEN_W'(blue);
    end else if (green == mx) begin
      num6 = (blue == mn) ? DEN_W'(2) * d11 - (DEN_W'(red) - DEN_W'(blue))
                          : DEN_W'(2) * d11 + (DEN_W'(blue) - DEN_W'(red));
    end else begin
      num6 = (red == mn) ? DEN_W'(4) * d11 - (DEN_W'(green) - DEN_W'(red))
                         : DEN_W'(4) * d11 + (DEN_W'(red) - DEN_W'(green));
    end
    // grey pixel divides zero by one
    if (d == '0) begin
      a_hn_nxt = '0;
      a_hd_nxt = DEN_W'(1);
      a_sn_nxt = '0;
      a_sd_nxt = DEN_W'(1);
    end else begin
      a_hn_nxt = (DIV_W'(num6) << FRAC_BITS) + DIV_W'(DEN_W'(3) * d11);
      a_hd_nxt = DEN_W'(6) * d11;
      a_sn_nxt = (DIV_W'(d) << (FRAC_BITS + 1)) + DIV_W'(mx);
      a_sd_nxt = DEN_W'(2) * DEN_W'(mx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_alpha_r <= alpha;
      a_sr_r    <= SQC_W'(red) * SQC_W'(red);
      a_sg_r    <= SQC_W'(green) * SQC_W'(green);
      a_sb_r    <= SQC_W'(blue) * SQC_W'(blue);
      a_hn_r    <= a_hn_nxt;
      a_hd_r    <= a_hd_nxt;
      a_sn_r    <= a_sn_nxt;
      a_sd_r    <= a_sd_nxt;
    end
  end

  // Stage B: weight the squares
  logic              b_vld_r;
  logic [CH_W-1:0]   b_alpha_r;
  logic [PROD_W-1:0] b_pr_r, b_pg_r, b_pb_r;
  logic [DIV_W-1:0]  b_hn_r, b_sn_r;
  logic [DEN_W-1:0]  b_hd_r, b_sd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_alpha_r <= a_alpha_r;
      b_pr_r    <= PROD_W'(red_w) * PROD_W'(a_sr_r);
      b_pg_r    <= PROD_W'(green_w) * PROD_W'(a_sg_r);
      b_pb_r    <= PROD_W'(blue_w) * PROD_W'(a_sb_r);
      b_hn_r    <= a_hn_r;
      b_hd_r    <= a_hd_r;
      b_sn_r    <= a_sn_r;
      b_sd_r    <= a_sd_r;
    end
  end

  // Stage C: sum, range check, seed the square root
  logic [SUM_W-1:0] sum;
  logic             big;
  logic [SQ_W-1:0]  yv;
  logic             c_vld_r;
  work_t            c_work_r, c_work_nxt;

  always_comb begin
    sum = SUM_W'(b_pr_r) + SUM_W'(b_pg_r) + SUM_W'(b_pb_r);
    big = (sum >= CAP);
    yv  = big ? '0 : (SQ_W'(sum) << SQ_SHIFT);
    c_work_nxt.alpha = b_alpha_r;
    c_work_nxt.big   = big;
    c_work_nxt.sq_r  = $signed(yv) - $signed(SQ_W'(CH_SQ));
    c_work_nxt.sq_m  = -$signed(SM_W'(CH_SQ));
    c_work_nxt.sq_p  = '0;
    c_work_nxt.h_rem = b_hn_r;
    c_work_nxt.h_den = b_hd_r;
    c_work_nxt.h_q   = '0;
    c_work_nxt.s_rem = b_sn_r;
    c_work_nxt.s_den = b_sd_r;
    c_work_nxt.s_q   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_work_r <= c_work_nxt;
    end
  end

  assign out_vld  = c_vld_r;
  assign out_work = c_work_r;
endmodule
`default_nettype wire

// ===== hdl/hsp_step.sv =====
`default_nettype none
module hsp_step #(
  parameter int BIT = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire hsp_pkg::work_t in_work,
  output logic                out_vld,
  output hsp_pkg::work_t      out_work
);
  import hsp_pkg::*;

  logic signed [SQ_W-1:0] m_ext, delta;
  logic                   take;
  logic [DIV_W-1:0]       h_sub, s_sub;
  logic                   vld_r;
  work_t                  work_r, work_nxt;

  // One result bit of the square root and of both dividers
  always_comb begin
    m_ext = SQ_W'(in_work.sq_m);
    delta = (m_ext <<< (BIT + 2)) + $signed(SQ_W'(CH_SQ) << (2 * BIT + 2));
    take  = !in_work.sq_p[OUT_W-1] && (delta <= in_work.sq_r);
    h_sub = DIV_W'(in_work.h_den) << BIT;
    s_sub = DIV_W'(in_work.s_den) << BIT;

    work_nxt = in_work;
    if (take) begin
      work_nxt.sq_r = in_work.sq_r - delta;
      work_nxt.sq_m = in_work.sq_m + $signed(SM_W'(CH_SQ) << (BIT + 1));
      work_nxt.sq_p = in_work.sq_p | (OUT_W'(1) << BIT);
    end
    if (in_work.h_rem >= h_sub) begin
      work_nxt.h_rem = in_work.h_rem - h_sub;
      work_nxt.h_q   = in_work.h_q | (OUT_W'(1) << BIT);
    end
    if (in_work.s_rem >= s_sub) begin
      work_nxt.s_rem = in_work.s_rem - s_sub;
      work_nxt.s_q   = in_work.s_q | (OUT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_r <= work_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_work = work_r;
endmodule
`default_nettype wire

// ===== hdl/rgb_to_hsp_converter.sv =====
`default_nettype none
// Throughput: one pixel per cycle; 3 front stages feed 17 iteration stages,
// each resolving one bit of the brightness root and of the hue and
// saturation quotients. The whole pipeline holds when the result is stalled.
// Reset (synchronous, rst_n low) clears all stage valid bits and loads the
// default brightness weights.
module rgb_to_hsp_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  hsp_pix_if.sink          in_pix,
  hsp_res_if.source        out_res
);
  import hsp_pkg::*;

  localparam int NSTEP = OUT_W;

  logic [WGT_W-1:0] red_w, green_w, blue_w;
  logic             en;
  logic             vld [NSTEP+1];
  work_t            work [NSTEP+1];
  work_t            last;

  assign cfg_pready = 1'b1;

  hsp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .red_w   (red_w),
    .green_w (green_w),
    .blue_w  (blue_w)
  );

  // Advance the pipeline unless a finished word is stalled
  assign en           = !vld[NSTEP] || out_res.ready;
  assign in_pix.ready = en;

  hsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_pix.valid),
    .red      (in_pix.red_in),
    .green    (in_pix.green_in),
    .blue     (in_pix.blue_in),
    .alpha    (in_pix.alpha_in),
    .red_w    (red_w),
    .green_w  (green_w),
    .blue_w   (blue_w),
    .out_vld  (vld[0]),
    .out_work (work[0])
  );

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    hsp_step #(.BIT(NSTEP - 1 - k)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld[k]),
      .in_work  (work[k]),
      .out_vld  (vld[k+1]),
      .out_work (work[k+1])
    );
  end

  // Cap at 1.0 and drive the result word
  assign last                   = work[NSTEP];
  assign out_res.valid          = vld[NSTEP];
  assign out_res.hue_out        = (last.h_q > ONE) ? ONE : last.h_q;
  assign out_res.saturation_out = (last.s_q > ONE) ? ONE : last.s_q;
  assign out_res.brightness_out = last.big ? ONE : last.sq_p;
  assign out_res.alpha_out      = last.alpha;

`ifndef SYNTHESIS
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> out_res.hue_out <= ONE)
    else $error("hue above 1.0");

  a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> out_res.brightness_out <= ONE)
    else $error("brightness above 1.0");

  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.saturation_out == '0) |-> out_res.hue_out == '0)
    else $error("hue without saturation");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_res.valid)
    else $error("result word valid after reset");
`endif
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import hsp_pkg::*;

  localparam int         PIPE_LAT   = 20;
  localparam int         WDOG_LIMIT = 2000;
  localparam logic [3:0] ADDR_UNUSED = 4'd12;

  typedef struct packed {
    logic [16:0] hue;
    logic [16:0] sat;
    logic [16:0] bright;
    logic [7:0]  alpha;
  } hsp_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  hsp_pix_if pix ();
  hsp_res_if res ();

  rgb_to_hsp_converter u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_pix(pix), .out_res(res)
  );

  always #5 clk = ~clk;

  // Weight mirror and pending results
  logic [16:0] wgt_red, wgt_green, wgt_blue;
  hsp_word_t   pending_hsp[$];
  int          n_errors = 0;
  int          n_pixels = 0;
  int          n_words = 0;
  int          n_cfg = 0;
  bit          calm = 0;
  int          rx_wait = 0;
  int          rx_hold = 0;
  int          idle_cycles = 0;

  initial begin
    pix.valid = 1'b0;
    pix.red_in = '0;
    pix.green_in = '0;
    pix.blue_in = '0;
    pix.alpha_in = '0;
    res.ready = 1'b0;
  end

  // Rounded root of the weighted sum, capped at 1.0
  function automatic logic [16:0] brightness_of(input logic [63:0] s);
    logic [127:0] lim, c, q, lhs;
    logic [16:0]  p;
    p = '0;
    if (s >= 64'd4261478400) return 17'h10000;
    lim = {64'd0, s} << 18;
    for (int bit_i = 16; bit_i >= 0; bit_i--) begin
      c = {111'd0, p} | (128'd1 << bit_i);
      if (c <= 128'h10000) begin
        q = 2 * c - 1;
        lhs = 128'd65025 * q * q;
        if (lhs <= lim) p = c[16:0];
      end
    end
    return p;
  endfunction

  function automatic hsp_word_t predict_hsp(input logic [7:0] r8, g8, b8, a8);
    hsp_word_t w;
    longint unsigned r, g, b, mx, mn, d, num6, h, s, sum;
    r = r8; g = g8; b = b8;
    sum = wgt_red * r * r + wgt_green * g * g + wgt_blue * b * b;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    d = mx - mn;
    h = 0;
    s = 0;
    if (d != 0) begin
      if (r == mx) num6 = (g == mn) ? 6 * d - (b - g) : (g - b);
      else if (g == mx) num6 = (b == mn) ? 2 * d - (r - b) : 2 * d + (b - r);
      else num6 = (r == mn) ? 4 * d - (g - r) : 4 * d + (r - g);
      h = (2 * num6 * 65536 + 6 * d) / (12 * d);
      if (h > 65536) h = 65536;
      s = (2 * d * 65536 + mx) / (2 * mx);
      if (s > 65536) s = 65536;
    end
    w.hue = h[16:0];
    w.sat = s[16:0];
    w.bright = brightness_of(sum);
    w.alpha = a8;
    return w;
  endfunction

  // Predict on every accepted pixel, check every accepted result word
  always @(posedge clk) begin
    hsp_word_t exp_w;
    if (rst_n && pix.valid && pix.ready) begin
      pending_hsp.push_back(predict_hsp(pix.red_in, pix.green_in, pix.blue_in,
                                        pix.alpha_in));
      n_pixels++;
    end
    if (rst_n && res.valid && res.ready) begin
      n_words++;
      rx_wait = calm ? 0 : $urandom_range(0, 6);
      if (pending_hsp.size() == 0) begin
        $error("result word with no pixel pending");
        n_errors++;
      end else begin
        exp_w = pending_hsp.pop_front();
        if (res.hue_out !== exp_w.hue) begin
          $error("hue_out: expected %0d, got %0d", exp_w.hue, res.hue_out);
          n_errors++;
        end
        if (res.saturation_out !== exp_w.sat) begin
          $error("saturation_out: expected %0d, got %0d", exp_w.sat, res.saturation_out);
          n_errors++;
        end
        if (res.brightness_out !== exp_w.bright) begin
          $error("brightness_out: expected %0d, got %0d", exp_w.bright,
                 res.brightness_out);
          n_errors++;
        end
        if (res.alpha_out !== exp_w.alpha) begin
          $error("alpha_out: expected %0d, got %0d", exp_w.alpha, res.alpha_out);
          n_errors++;
        end
      end
    end
  end

  // Receiver: long hold-off first, then per-word stalls
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      res.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || cfg_psel)
      idle_cycles <= 0;
    else if (rst_n)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("rgb_to_hsp_converter test failed");
      $finish;
    end
  end

  // Offer one pixel; called at a falling edge, returns at a falling edge
  task automatic send_pixel(input logic [7:0] r, g, b, a);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix.valid <= 1'b1;
    pix.red_in <= r;
    pix.green_in <= g;
    pix.blue_in <= b;
    pix.alpha_in <= a;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Lower valid and wait until every result word is back
  task automatic drain;
    pix.valid <= 1'b0;
    @(negedge clk);
    while (pending_hsp.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 5) @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (addr)
      4'(4 * REG_RED):   wgt_red = data[16:0];
      4'(4 * REG_GREEN): wgt_green = data[16:0];
      4'(4 * REG_BLUE):  wgt_blue = data[16:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic set_weights(input logic [16:0] wr, wg, wb);
    write_reg(4'(4 * REG_RED), {15'd0, wr});
    write_reg(4'(4 * REG_GREEN), {15'd0, wg});
    write_reg(4'(4 * REG_BLUE), {15'd0, wb});
  endtask

  // Channel value biased toward the ends and toward ties
  function automatic logic [7:0] pick_chan(input logic [7:0] other);
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return other;
      3: return other + 8'($urandom_range(0, 2)) - 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [7:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      r = 8'($urandom);
      g = pick_chan(r);
      b = ($urandom_range(0, 1) == 1) ? pick_chan(g) : pick_chan(r);
      send_pixel(r, g, b, 8'($urandom));
    end
  endtask

  // Extremes, grey, ties, every sextant, pure red family
  task automatic test_directed;
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128, 8'd170);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd85);
    send_pixel(8'd200, 8'd50, 8'd50, 8'd1);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd2);
    send_pixel(8'd0, 8'd0, 8'd255, 8'd4);
    send_pixel(8'd255, 8'd255, 8'd0, 8'd8);
    send_pixel(8'd0, 8'd255, 8'd255, 8'd16);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd32);
    send_pixel(8'd200, 8'd100, 8'd10, 8'd64);
    send_pixel(8'd200, 8'd10, 8'd100, 8'd128);
    send_pixel(8'd100, 8'd200, 8'd10, 8'd3);
    send_pixel(8'd10, 8'd200, 8'd100, 8'd5);
    send_pixel(8'd10, 8'd100, 8'd200, 8'd9);
    send_pixel(8'd100, 8'd10, 8'd200, 8'd17);
    send_pixel(8'd255, 8'd1, 8'd0, 8'd33);
    send_pixel(8'd255, 8'd0, 8'd1, 8'd65);
    send_pixel(8'd1, 8'd0, 8'd0, 8'd129);
    send_pixel(8'd255, 8'd254, 8'd254, 8'd254);
    drain();
  endtask

  // Weight extremes, including sums far above 1.0 and a stray address
  task automatic test_weights;
    set_weights(17'd0, 17'd0, 17'd0);
    send_random(100);
    drain();
    set_weights(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    write_reg(ADDR_UNUSED, 32'hFFFF_FFFF);
    send_random(150);
    drain();
    set_weights(17'h10000, 17'd0, 17'd0);
    send_random(150);
    drain();
    set_weights(17'd0, 17'h10000, 17'd1);
    send_random(150);
    drain();
    set_weights(17'($urandom), 17'($urandom), 17'($urandom));
    send_random(200);
    drain();
    set_weights(17'd19595, 17'd38470, 17'd7471);
  endtask

  // Hold the receiver off so the pipeline fills and stalls its input
  task automatic test_backpressure;
    calm = 1;
    rx_hold = 200;
    send_random(80);
    calm = 0;
    drain();
  endtask

  // Random traffic with burst stretches and full pauses in between
  task automatic test_random;
    for (int blk = 0; blk < 10; blk++) begin
      calm = (blk % 3 == 1);
      send_random(120);
      if (blk % 4 == 3) drain();
    end
    calm = 0;
    drain();
  endtask

  initial begin
    wgt_red = 17'd19595;
    wgt_green = 17'd38470;
    wgt_blue = 17'd7471;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_weights();
    test_backpressure();
    test_random();
    $display("Sent %0d pixels and checked %0d result words over %0d register writes,",
             n_pixels, n_words, n_cfg);
    $display("covering weight extremes, grey and tie cases, and long output stalls.");
    if (n_errors == 0 && pending_hsp.size() == 0) begin
      $display("rgb_to_hsp_converter test passed");
    end else begin
      $display("rgb_to_hsp_converter test failed");
    end
    $finish;
  end
endmodule
